// File: design/mtx_pkg.sv
package mtx_pkg;

    // Tracking modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_VT200 = 2'd1;
    localparam logic [1:0] MODE_DRAG  = 2'd2;
    localparam logic [1:0] MODE_ANY   = 2'd3;

    // Register indexes on the configuration port (taken from paddr[2])
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_ENC  = 1'b1;

    // Report characters
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;  // '['
    localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
    localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
    localparam logic [7:0] CH_M    = 8'h4D;  // 'M'
    localparam logic [7:0] CH_LM   = 8'h6D;  // 'm'
    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_OFS  = 8'h20;
    localparam logic [15:0] LEGACY_MAX = 16'd223;

    // Byte positions within one report
    localparam logic [3:0] PART_ESC   = 4'd0;
    localparam logic [3:0] PART_LBR   = 4'd1;
    localparam logic [3:0] PART_INTRO = 4'd2;  // '<' or 'M'
    localparam logic [3:0] PART_CODE  = 4'd3;
    localparam logic [3:0] PART_SEP1  = 4'd4;  // legacy: column byte
    localparam logic [3:0] PART_XDIG  = 4'd5;  // legacy: row byte
    localparam logic [3:0] PART_SEP2  = 4'd6;
    localparam logic [3:0] PART_YDIG  = 4'd7;
    localparam logic [3:0] PART_FINAL = 4'd8;

    // Pending report bits, in report order
    localparam int REP_LEFT   = 0;
    localparam int REP_MIDDLE = 1;
    localparam int REP_RIGHT  = 2;
    localparam int REP_VWHEEL = 3;
    localparam int REP_HWHEEL = 4;
    localparam int REP_MOTION = 5;

    localparam int CONV_STEPS = 16;

    typedef struct packed {
        logic load;
        logic conv;
        logic emit;
    } mtx_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic none_pending;
        logic item_done;
    } mtx_sts_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } mtx_state_t;

    // Number of significant decimal digits in a 5-digit BCD word, at least one.
    function automatic logic [2:0] bcd_digits(input logic [19:0] b);
        logic [2:0] n;
        if (b[19:16] != 4'd0)
        begin
            n = 3'd5;
        end
        else if (b[15:12] != 4'd0)
        begin
            n = 3'd4;
        end
        else if (b[11:8] != 4'd0)
        begin
            n = 3'd3;
        end
        else if (b[7:4] != 4'd0)
        begin
            n = 3'd2;
        end
        else
        begin
            n = 3'd1;
        end
        return n;
    endfunction

endpackage

// File: design/mtx_ctrl.sv
module mtx_ctrl
    import mtx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  mtx_sts_t sts,
    output mtx_cmd_t cmd,
    output logic     idle
);

    mtx_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        idle       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle     = 1'b1;
                cmd.load = start;
                if (start)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (sts.conv_last)
                begin
                    state_next = sts.none_pending ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.item_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/mtx_datapath.sv
module mtx_datapath
    import mtx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mtx_cmd_t    cmd,
    output mtx_sts_t    sts,
    input  logic [1:0]  mode,
    input  logic        enc,
    input  logic [55:0] in_data,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [39:0] out_data,
    output logic        out_last
);

    // Input item fields
    logic [2:0]  btn_in;
    logic [15:0] delta_in;
    logic        vw_in, hw_in, moved_in;
    logic [2:0]  mods_in;
    logic [14:0] col_in, row_in;

    assign btn_in   = in_data[2:0];
    assign delta_in = in_data[18:3];
    assign vw_in    = in_data[19];
    assign hw_in    = in_data[20];
    assign moved_in = in_data[21];
    assign mods_in  = in_data[24:22];
    assign col_in   = in_data[39:25];
    assign row_in   = in_data[54:40];

    logic [2:0]  prev_reg, btn_reg;
    logic [2:0]  mods_reg;
    logic [5:0]  pend_reg;
    logic        vup_reg, hleft_reg;
    logic [1:0]  mbtn_reg;
    logic [7:0]  xl_reg, yl_reg;
    logic [15:0] xs_reg, ys_reg;
    logic [19:0] xb_reg, yb_reg;
    logic [3:0]  cnt_reg;
    logic [3:0]  part_reg;
    logic [2:0]  di_reg;
    logic [7:0]  acc_reg [3];
    logic [1:0]  acc_cnt_reg;
    logic        out_valid_reg;
    logic [31:0] out_bytes_reg;
    logic [2:0]  out_cnt_reg;
    logic        out_last_reg;

    // Load-time decode
    logic [15:0] x_in, y_in;
    logic [5:0]  pend_load;
    logic        mode_on;

    assign x_in    = {1'b0, col_in} + 16'd1;
    assign y_in    = {1'b0, row_in} + 16'd1;
    assign mode_on = (mode != MODE_NONE);

    always_comb
    begin
        pend_load[REP_LEFT]   = btn_in[0] ^ prev_reg[0];
        pend_load[REP_MIDDLE] = btn_in[1] ^ prev_reg[1];
        pend_load[REP_RIGHT]  = btn_in[2] ^ prev_reg[2];
        pend_load[REP_VWHEEL] = vw_in & mode_on;
        pend_load[REP_HWHEEL] = hw_in & mode_on;
        pend_load[REP_MOTION] = (pend_load[4:0] == 5'd0) && moved_in &&
            ((mode == MODE_ANY) || ((mode == MODE_DRAG) && (btn_in != 3'd0)));
    end

    // Double-dabble step on both coordinates
    function automatic logic [19:0] add3(input logic [19:0] b);
        logic [19:0] r;
        for (int k = 0; k < 5; k++)
        begin
            r[k*4 +: 4] = (b[k*4 +: 4] >= 4'd5) ? b[k*4 +: 4] + 4'd3 : b[k*4 +: 4];
        end
        return r;
    endfunction

    logic [19:0] xb_adj, yb_adj;
    assign xb_adj = add3(xb_reg);
    assign yb_adj = add3(yb_reg);

    // Current report: lowest pending bit
    logic [5:0]  sel;
    logic [4:0]  mods5;
    logic [6:0]  code;
    logic        release_rep;
    logic [7:0]  lcode;

    assign sel   = pend_reg & (~pend_reg + 6'd1);
    assign mods5 = {mods_reg, 2'b00};

    always_comb
    begin
        code        = {2'b00, mods5};
        release_rep = 1'b0;
        case (1'b1)
            sel[REP_LEFT]:
            begin
                release_rep = ~btn_reg[0];
            end
            sel[REP_MIDDLE]:
            begin
                code        = {2'b00, mods5} + 7'd1;
                release_rep = ~btn_reg[1];
            end
            sel[REP_RIGHT]:
            begin
                code        = {2'b00, mods5} + 7'd2;
                release_rep = ~btn_reg[2];
            end
            sel[REP_VWHEEL]:
            begin
                code = {2'b00, mods5} + (vup_reg ? 7'd64 : 7'd65);
            end
            sel[REP_HWHEEL]:
            begin
                code = {2'b00, mods5} + (hleft_reg ? 7'd66 : 7'd67);
            end
            sel[REP_MOTION]:
            begin
                code = {2'b00, mods5} + 7'd32 + {5'd0, mbtn_reg};
            end
            default:
            begin
                code = {2'b00, mods5};
            end
        endcase
    end

    assign lcode = CH_OFS + (release_rep ? {3'b000, mods5 | 5'd3} : {1'b0, code});

    // Two-digit decimal split of the button code (code stays below 100)
    logic [14:0] tens_prod;
    logic [3:0]  tens, ones;
    logic [6:0]  ones_w;
    logic [2:0]  code_nd;

    assign tens_prod = 15'(code) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones_w    = code - {tens, 3'b000} - {2'b00, tens, 1'b0};
    assign ones      = ones_w[3:0];
    assign code_nd   = (code >= 7'd10) ? 3'd2 : 3'd1;

    logic [3:0] xdig [5];
    logic [3:0] ydig [5];
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            xdig[3'(k)] = xb_reg[k*4 +: 4];
            ydig[3'(k)] = yb_reg[k*4 +: 4];
        end
    end

    // Byte generator
    logic [7:0] cur_byte;
    logic       digit_part, at_end, item_final;

    always_comb
    begin
        cur_byte = CH_ESC;
        if (enc)
        begin
            case (part_reg)
                PART_ESC:   cur_byte = CH_ESC;
                PART_LBR:   cur_byte = CH_LBR;
                PART_INTRO: cur_byte = CH_LT;
                PART_CODE:  cur_byte = CH_ZERO + {4'd0, (di_reg[0] ? tens : ones)};
                PART_SEP1:  cur_byte = CH_SEMI;
                PART_XDIG:  cur_byte = CH_ZERO + {4'd0, xdig[di_reg]};
                PART_SEP2:  cur_byte = CH_SEMI;
                PART_YDIG:  cur_byte = CH_ZERO + {4'd0, ydig[di_reg]};
                PART_FINAL: cur_byte = release_rep ? CH_LM : CH_M;
                default:    cur_byte = CH_ESC;
            endcase
        end
        else
        begin
            case (part_reg)
                PART_ESC:   cur_byte = CH_ESC;
                PART_LBR:   cur_byte = CH_LBR;
                PART_INTRO: cur_byte = CH_M;
                PART_CODE:  cur_byte = lcode;
                PART_SEP1:  cur_byte = xl_reg;
                PART_XDIG:  cur_byte = yl_reg;
                default:    cur_byte = CH_ESC;
            endcase
        end
    end

    assign digit_part = enc && ((part_reg == PART_CODE) || (part_reg == PART_XDIG) ||
                                (part_reg == PART_YDIG));
    assign at_end     = enc ? (part_reg == PART_FINAL) : (part_reg == PART_XDIG);
    assign item_final = at_end && ((pend_reg & ~sel) == 6'd0);

    logic out_free, need_out, consume;
    assign out_free = ~out_valid_reg | out_ready;
    assign need_out = (acc_cnt_reg == 2'd3) || item_final;
    assign consume  = cmd.emit && (~need_out || out_free);

    logic [31:0] chunk;
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (2'(j) < acc_cnt_reg && j < 3)
            begin
                chunk[j*8 +: 8] = acc_reg[2'(j)];
            end
            else if (j == 32'(acc_cnt_reg))
            begin
                chunk[j*8 +: 8] = cur_byte;
            end
            else
            begin
                chunk[j*8 +: 8] = 8'd0;
            end
        end
    end

    assign sts.conv_last    = (cnt_reg == 4'(CONV_STEPS - 1));
    assign sts.none_pending = (pend_reg == 6'd0);
    assign sts.item_done    = consume && item_final;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= 3'd0;
            pend_reg      <= 6'd0;
            cnt_reg       <= 4'd0;
            part_reg      <= PART_ESC;
            di_reg        <= 3'd0;
            acc_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new chunk entering the output register keeps it full even
            // when the previous one leaves in the same cycle.
            if (consume && need_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                prev_reg <= btn_in;
                pend_reg <= pend_load;
                cnt_reg  <= 4'd0;
                part_reg <= PART_ESC;
            end
            if (cmd.conv)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (consume)
            begin
                if (digit_part && (di_reg != 3'd0))
                begin
                    di_reg <= di_reg - 3'd1;
                end
                else if (at_end)
                begin
                    part_reg <= PART_ESC;
                    pend_reg <= pend_reg & ~sel;
                end
                else
                begin
                    part_reg <= part_reg + 4'd1;
                    case (part_reg + 4'd1)
                        PART_CODE: di_reg <= code_nd - 3'd1;
                        PART_XDIG: di_reg <= bcd_digits(xb_reg) - 3'd1;
                        PART_YDIG: di_reg <= bcd_digits(yb_reg) - 3'd1;
                        default:   di_reg <= 3'd0;
                    endcase
                end
                if (need_out)
                begin
                    acc_cnt_reg <= 2'd0;
                end
                else
                begin
                    acc_cnt_reg <= acc_cnt_reg + 2'd1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            btn_reg   <= btn_in;
            mods_reg  <= mods_in;
            vup_reg   <= ($signed(delta_in) >= 16'sd120);
            hleft_reg <= ($signed(delta_in) <= -16'sd120);
            mbtn_reg  <= btn_in[0] ? 2'd0 : btn_in[1] ? 2'd1 : btn_in[2] ? 2'd2 : 2'd3;
            xl_reg    <= (x_in > LEGACY_MAX) ? 8'd0 : x_in[7:0] + CH_OFS;
            yl_reg    <= (y_in > LEGACY_MAX) ? 8'd0 : y_in[7:0] + CH_OFS;
            xs_reg    <= x_in;
            ys_reg    <= y_in;
            xb_reg    <= 20'd0;
            yb_reg    <= 20'd0;
        end
        if (cmd.conv)
        begin
            {xb_reg, xs_reg} <= {xb_adj[18:0], xs_reg, 1'b0};
            {yb_reg, ys_reg} <= {yb_adj[18:0], ys_reg, 1'b0};
        end
        if (consume)
        begin
            if (need_out)
            begin
                out_bytes_reg <= chunk;
                out_cnt_reg   <= {1'b0, acc_cnt_reg} + 3'd1;
                out_last_reg  <= item_final;
            end
            else
            begin
                acc_reg[acc_cnt_reg] <= cur_byte;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {5'd0, out_cnt_reg, out_bytes_reg};
    assign out_last  = out_last_reg;

endmodule

// File: design/mouse_event_to_xterm_report_top.sv
// Mouse event to xterm report encoder. Each input item is one pointer event;
// the block compares the buttons against those of the previous event and
// sends xterm mouse reports for left, middle and right press or release, then
// the vertical and horizontal wheel, or a motion report when nothing else was
// sent and the tracking mode asks for it. Reports are SGR decimal or legacy
// six-byte form, and their bytes leave packed four to an output item, with
// tlast on the final one of the event. An event with nothing to report yields
// no output item. Per event the block captures it, runs the double-dabble
// unit that turns both coordinates into decimal, then generates the report
// bytes (up to 90 bytes for five SGR reports), waiting while the output side
// stalls; one byte is put out a cycle unless a full item waits on the
// output. A new event is taken once the last byte of the previous one is in
// the output register. Configuration (tracking_mode at 0x0, decimal_encoding
// at 0x4) may be written only while no event is in progress.
module mouse_event_to_xterm_report_top
    import mtx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input item
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: btn_left, btn_middle, btn_right, wheel_delta[15:0],
    // vertical_wheel, horizontal_wheel, moved, shift_down, alt_down, ctrl_down,
    // column[14:0], row[14:0], one zero pad bit
    input  logic [55:0] s_tdata,
    // Output item
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: byte_0, byte_1, byte_2, byte_3, byte_count[2:0], zero pad
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] mode_reg;
    logic       enc_reg;
    logic       cfg_wr;

    // Register write happens in the access phase; the register is picked by
    // the word address bit.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NONE;
            enc_reg  <= 1'b1;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MODE)
            begin
                mode_reg <= pwdata[1:0];
            end
            else
            begin
                enc_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ENC) ? {31'd0, enc_reg} : {30'd0, mode_reg};

    mtx_cmd_t cmd;
    mtx_sts_t sts;
    logic     idle;

    // The controller takes a new event only when it is idle.
    assign s_tready = idle;

    mtx_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s_tvalid),
        .sts   (sts),
        .cmd   (cmd),
        .idle  (idle)
    );

    mtx_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode_reg),
        .enc       (enc_reg),
        .in_data   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// File: test/mouse_report_checker.sv
`timescale 1ns / 1ps

// Watches the event and report channels, predicts the report bytes of every
// accepted event and compares each output item against the oldest prediction.
module mouse_report_checker
    import mtx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending_chunks,
    output int          chunk_total
);

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] cnt;
        logic       last;
    } chunk_t;

    chunk_t     expected_chunks[$];
    logic [1:0] mode_q;
    logic       sgr_q;
    logic [2:0] held_q;
    logic [7:0] report_bytes[$];

    assign pending_chunks = expected_chunks.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic push_decimal(input int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            report_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] legacy_coord(input int unsigned c);
        return (c < 1 || c > 223) ? 8'd0 : 8'(c + CH_OFS);
    endfunction

    task automatic add_report(input int unsigned code, input int unsigned x,
                              input int unsigned y, input logic release_evt);
        report_bytes.push_back(CH_ESC);
        report_bytes.push_back(CH_LBR);
        if (sgr_q)
        begin
            report_bytes.push_back(CH_LT);
            push_decimal(code);
            report_bytes.push_back(CH_SEMI);
            push_decimal(x);
            report_bytes.push_back(CH_SEMI);
            push_decimal(y);
            report_bytes.push_back(release_evt ? CH_LM : CH_M);
        end
        else
        begin
            if (release_evt)
                code = (code & 'h1C) | 3;
            report_bytes.push_back(CH_M);
            report_bytes.push_back(8'(CH_OFS + code));
            report_bytes.push_back(legacy_coord(x));
            report_bytes.push_back(legacy_coord(y));
        end
    endtask

    // Predicts the output items of one event, following the report order
    // left, middle, right, vertical wheel, horizontal wheel, then motion.
    task automatic encode_event(input logic [55:0] d);
        logic [2:0]         now;
        logic signed [15:0] delta;
        logic               vw;
        logic               hw;
        logic               any_sent;
        int unsigned        mods;
        int unsigned        x;
        int unsigned        y;
        int unsigned        code;
        int                 n;
        chunk_t             c;
        now = d[2:0];
        delta = d[18:3];
        vw = d[19] && mode_q != MODE_NONE;
        hw = d[20] && mode_q != MODE_NONE;
        mods = (d[22] ? 4 : 0) + (d[23] ? 8 : 0) + (d[24] ? 16 : 0);
        x = d[39:25] + 1;
        y = d[54:40] + 1;
        any_sent = 0;
        report_bytes.delete();
        for (int b = 0; b < 3; b++)
            if (now[b] != held_q[b])
            begin
                add_report(mods + b, x, y, !now[b]);
                any_sent = 1;
            end
        if (vw)
        begin
            add_report(mods + (delta >= 120 ? 64 : 65), x, y, 0);
            any_sent = 1;
        end
        if (hw)
        begin
            add_report(mods + (delta <= -120 ? 66 : 67), x, y, 0);
            any_sent = 1;
        end
        if (!any_sent && d[21] &&
            (mode_q == MODE_ANY || (mode_q == MODE_DRAG && now != 0)))
        begin
            code = mods | 32;
            code += now[0] ? 0 : now[1] ? 1 : now[2] ? 2 : 3;
            add_report(code, x, y, 0);
        end
        held_q = now;
        n = report_bytes.size();
        for (int k = 0; k < n; k += 4)
        begin
            c = '0;
            c.cnt = (n - k > 4) ? 3'd4 : 3'(n - k);
            c.b0 = report_bytes[k];
            if (c.cnt > 1) c.b1 = report_bytes[k + 1];
            if (c.cnt > 2) c.b2 = report_bytes[k + 2];
            if (c.cnt > 3) c.b3 = report_bytes[k + 3];
            c.last = (k + 4 >= n);
            expected_chunks.push_back(c);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        chunk_t want;
        if (!rst_n)
        begin
            mode_q = MODE_NONE;
            sgr_q = 1'b1;
            held_q = '0;
            fail_count = 0;
            chunk_total = 0;
            expected_chunks.delete();
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == REG_MODE)
                    mode_q = pwdata[1:0];
                else
                    sgr_q = pwdata[0];
            end
            if (s_tvalid && s_tready)
                encode_event(s_tdata);
            if (m_tvalid && m_tready)
            begin
                chunk_total++;
                if (expected_chunks.size() == 0)
                    report_mismatch("unexpected item", m_tdata[31:0], 0);
                else
                begin
                    want = expected_chunks.pop_front();
                    if (m_tdata[7:0] != want.b0)
                        report_mismatch("byte_0", m_tdata[7:0], want.b0);
                    if (m_tdata[15:8] != want.b1)
                        report_mismatch("byte_1", m_tdata[15:8], want.b1);
                    if (m_tdata[23:16] != want.b2)
                        report_mismatch("byte_2", m_tdata[23:16], want.b2);
                    if (m_tdata[31:24] != want.b3)
                        report_mismatch("byte_3", m_tdata[31:24], want.b3);
                    if (m_tdata[34:32] != want.cnt)
                        report_mismatch("byte_count", m_tdata[34:32], want.cnt);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
        end
    end

endmodule

// File: test/mouse_event_to_xterm_report_top_test.sv
`timescale 1ns / 1ps

// Stimulus top for the mouse report encoder. It writes the two mode registers
// between phases, sends directed and random pointer events in bursts, stalls
// the output side on its own pattern and gives the verdict from the failure
// count of the checker.
module mouse_event_to_xterm_report_top_test;
    import mtx_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_chunks;
    int          chunk_total;
    int          event_total;
    int          idle_cycles;
    // While set, the output side holds m_tready low for a long stretch.
    logic        hold_off;

    mouse_event_to_xterm_report_top dut (.*);

    mouse_report_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
    end

    // Output stall pattern: mostly ready, with short random stalls, runs of
    // full readiness, and the long hold-off when asked for.
    initial
    begin
        int phase;
        m_tready = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (hold_off)
                m_tready <= 0;
            else if ((phase / 64) % 3 == 0)
                m_tready <= 1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog: the run ends if nothing moves for too long. The limit lies far
    // above the time of the slowest event, output stalls included.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("** mouse_event_to_xterm_report_top: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // Waits until every predicted item has come out, then lets the block
    // settle, since an event with nothing to report leaves no trace.
    task automatic drain();
        while (pending_chunks != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_modes(input logic [1:0] mode, input logic sgr);
        drain();
        write_reg({REG_MODE, 2'b00}, {30'd0, mode});
        write_reg({REG_ENC, 2'b00}, {31'd0, sgr});
    endtask

    // Offers one event and holds it until the block takes it.
    task automatic send_event(input logic [55:0] d);
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        event_total++;
    endtask

    function automatic logic [55:0] pack_event(input logic [2:0] btn,
        input logic [15:0] delta, input logic vw, input logic hw, input logic mv,
        input logic [2:0] mods, input logic [14:0] col, input logic [14:0] row);
        return {1'b0, row, col, mods, mv, hw, vw, delta, btn};
    endfunction

    // Random coordinate biased toward the edges of the legacy range.
    function automatic logic [14:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 15'd0;
            1: return 15'($urandom_range(220, 224));
            2: return 15'h7FFF;
            3: return 15'($urandom);
            default: return 15'($urandom_range(0, 300));
        endcase
    endfunction

    function automatic logic [15:0] rand_delta();
        case ($urandom_range(0, 4))
            0: return 16'd120;
            1: return 16'hFF88;
            2: return 16'($urandom_range(118, 122));
            3: return -16'($urandom_range(118, 122));
            default: return 16'($urandom);
        endcase
    endfunction

    // Random events in bursts with gaps; mostly plausible button sequences.
    task automatic random_events(input int count);
        logic [2:0] btn;
        btn = 0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                btn = 3'($urandom);
            else if ($urandom_range(0, 1) == 0)
                btn[$urandom_range(0, 2)] ^= 1'b1;
            send_event(pack_event(btn, rand_delta(), $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0, $urandom_range(0, 1), 3'($urandom),
                rand_coord(), rand_coord()));
            if ($urandom_range(0, 3) == 0)
            begin
                s_tvalid <= 0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        s_tvalid <= 0;
    endtask

    initial
    begin
        s_tvalid = 0;
        s_tdata = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        hold_off = 0;
        event_total = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed part, at reset settings (no tracking, SGR): presses and
        // releases still report, wheel and motion do not.
        send_event(pack_event(3'b001, 16'd0, 0, 0, 0, 3'b000, 15'd0, 15'd0));
        send_event(pack_event(3'b110, 16'd120, 1, 1, 1, 3'b111, 15'h7FFF, 15'h7FFF));
        send_event(pack_event(3'b000, 16'd0, 1, 0, 1, 3'b101, 15'd5, 15'd9));
        s_tvalid <= 0;

        // VT200 legacy: wheels, mostly both together, coordinates around 223 and at the extremes.
        set_modes(MODE_VT200, 0);
        send_event(pack_event(3'b000, 16'd120, 1, 1, 0, 3'b000, 15'd222, 15'd223));
        send_event(pack_event(3'b000, 16'h8000, 1, 1, 0, 3'b010, 15'd0, 15'h7FFF));
        send_event(pack_event(3'b111, 16'h7FFF, 1, 1, 0, 3'b111, 15'd100, 15'd50));
        send_event(pack_event(3'b000, 16'hFF88, 0, 1, 0, 3'b100, 15'd1, 15'd2));
        send_event(pack_event(3'b000, 16'd0, 0, 0, 1, 3'b000, 15'd3, 15'd4));
        s_tvalid <= 0;

        // Drag mode, SGR: motion only with a button held, and suppressed
        // when a press was reported in the same event.
        set_modes(MODE_DRAG, 1);
        send_event(pack_event(3'b000, 16'd0, 0, 0, 1, 3'b000, 15'd7, 15'd7));
        send_event(pack_event(3'b010, 16'd0, 0, 0, 1, 3'b000, 15'd7, 15'd7));
        send_event(pack_event(3'b010, 16'd0, 0, 0, 1, 3'b011, 15'd8, 15'd7));
        send_event(pack_event(3'b100, 16'd0, 0, 0, 1, 3'b000, 15'd8, 15'd9));
        send_event(pack_event(3'b100, 16'd0, 0, 0, 1, 3'b000, 15'd9, 15'd9));
        s_tvalid <= 0;

        // Any-motion legacy: motion with and without a button held.
        set_modes(MODE_ANY, 0);
        send_event(pack_event(3'b000, 16'd0, 0, 0, 1, 3'b000, 15'd10, 15'd300));
        send_event(pack_event(3'b000, 16'd0, 0, 0, 1, 3'b111, 15'd223, 15'd222));
        send_event(pack_event(3'b001, 16'd0, 0, 0, 1, 3'b000, 15'd1, 15'd1));
        send_event(pack_event(3'b001, 16'd0, 0, 0, 1, 3'b000, 15'd2, 15'd1));
        s_tvalid <= 0;

        // Random phases in any-motion SGR and drag legacy, extremes included.
        set_modes(MODE_ANY, 1);
        random_events(40);
        set_modes(MODE_DRAG, 0);
        random_events(30);

        // Long output hold-off while events keep coming, so the block backs up.
        set_modes(MODE_VT200, 1);
        hold_off = 1;
        fork
            random_events(10);
            repeat (600) @(posedge clk);
        join_any
        hold_off = 0;
        wait fork;

        // The sender pauses until every expected item has arrived.
        drain();
        set_modes(MODE_NONE, 0);
        random_events(30);
        set_modes(MODE_ANY, 0);
        random_events(30);
        set_modes(MODE_DRAG, 1);
        random_events(40);

        drain();
        $display("covered %0d pointer events and %0d report items", event_total, chunk_total);
        $display("across all four tracking modes in both SGR and legacy encoding");
        if (fail_count == 0)
            $display("** mouse_event_to_xterm_report_top: PASSED **");
        else
            $display("** mouse_event_to_xterm_report_top: FAILED **");
        $finish;
    end

endmodule
